// ===== design/lfr_pkg.sv =====
// Shared types, constants and controller encodings for the largest free rectangle block.
package lfr_pkg;

  localparam int CW = 16;
  localparam int AW = 32;
  localparam int DEF_MAX_OCC = 16;
  localparam int DEF_COORD_BITS = 16;

  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_OCC = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic signed [CW-1:0] x_min;
    logic signed [CW-1:0] y_min;
    logic signed [CW-1:0] x_max;
    logic signed [CW-1:0] y_max;
    logic                 last;
  } in_word_t;

  typedef struct packed {
    logic signed [CW-1:0] free_x_min;
    logic signed [CW-1:0] free_y_min;
    logic signed [CW-1:0] free_x_max;
    logic signed [CW-1:0] free_y_max;
    logic [AW-1:0]        free_area;
    logic                 dropped;
  } out_word_t;

  typedef struct packed {
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
  } box_t;

  typedef struct packed {
    logic signed [CW-1:0] left;
    logic [CW-1:0]        height;
  } bar_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_GRID,
    ST_CHECK,
    ST_WIN,
    ST_MARK,
    ST_ROW,
    ST_COL,
    ST_POP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take;
    logic init;
    logic grid;
    logic check;
    logic win;
    logic mark;
    logic row;
    logic col;
    logic pop;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic win_empty;
    logic grid_done;
    logic any_clip;
    logic mark_done;
    logic rows_done;
    logic col_pop;
    logic col_last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic init;
    logic ins;
    logic rot;
    logic shf;
  } sort_cmd_t;

endpackage

// ===== design/largest_free_rectangle.sv =====
// Top level of the largest free rectangle finder.
// Words are taken one per cycle while the block is idle: a window word opens a job, occluder
// words follow, and the word marked last closes it and produces one result word. From then
// on the input stalls until the result is in the output register. A closed job first builds
// the grid and then marks coverage over the K stored occluders, then sweeps each grid row
// column by column with stack pops; the sweep over its bar stack dominates. An empty window
// goes straight to the finish, and a window with no visible occluder skips marking and the
// sweep. A finished result may wait in the output register while the next job loads.
module largest_free_rectangle import lfr_pkg::*; #(
  parameter int MAX_OCC    = DEF_MAX_OCC,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  cmd_t cmd;
  sts_t sts;

  lfr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_last(in_word.last),
    .in_stall(in_stall), .sts(sts), .cmd(cmd)
  );

  lfr_dpath #(.MAX_OCC(MAX_OCC), .COORD_BITS(COORD_BITS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_word(in_word),
    .out_word(out_word), .out_valid(out_valid), .out_stall(out_stall)
  );

endmodule

// ===== design/lfr_sort.sv =====
// Sorted, deduplicated grid line register row with insert, rotate and shift.
module lfr_sort import lfr_pkg::*; #(
  parameter int LINES = 2 * DEF_MAX_OCC + 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sort_cmd_t                      cmd,
  input  logic signed [CW-1:0]           v0,
  input  logic signed [CW-1:0]           v1,
  output logic [LINES-1:0][CW-1:0]       line_o,
  output logic [$clog2(LINES+1)-1:0]     n_o
);

  localparam int NW = $clog2(LINES + 1);

  logic [CW-1:0]    line_r   [LINES];
  logic [CW-1:0]    line_nxt [LINES];
  logic [NW-1:0]    n_r, n_nxt;
  logic [LINES-1:0] lt;
  logic [LINES-1:0] eq;
  logic             dup;

  assign dup = |eq;

  for (genvar k = 0; k < LINES; k++) begin : g_cell
    localparam int NX = (k + 1) % LINES;
    localparam int PV = (k + LINES - 1) % LINES;

    assign lt[k] = (NW'(k) < n_r) && ($signed(line_r[k]) < v0);
    assign eq[k] = (NW'(k) < n_r) && ($signed(line_r[k]) == v0);
    assign line_o[k] = line_r[k];

    always_comb begin
      line_nxt[k] = line_r[k];
      if (cmd.init) begin
        if (k == 0) line_nxt[k] = v0;
        else if (k == 1) line_nxt[k] = v1;
      end else if (cmd.ins && !dup) begin
        if (!lt[k]) line_nxt[k] = (k == 0 || lt[PV]) ? v0 : line_r[PV];
      end else if (cmd.rot) begin
        line_nxt[k] = (NW'(k) == n_r - 1'b1 || k == LINES - 1) ? line_r[0] : line_r[NX];
      end else if (cmd.shf) begin
        line_nxt[k] = line_r[NX];
      end
    end
  end

  always_comb begin
    n_nxt = n_r;
    if (cmd.init) n_nxt = NW'(2);
    else if (cmd.ins && !dup) n_nxt = n_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LINES; k++) line_r[k] <= line_nxt[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) n_r <= '0;
    else n_r <= n_nxt;
  end

  assign n_o = n_r;

endmodule

// ===== design/lfr_dpath.sv =====
// Datapath: occluder store, clipping, grid, coverage map and histogram stack sweep.
module lfr_dpath import lfr_pkg::*; #(
  parameter int MAX_OCC    = DEF_MAX_OCC,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  in_word_t  in_word,
  output out_word_t out_word,
  output logic      out_valid,
  input  logic      out_stall
);

  localparam int LINES   = 2 * MAX_OCC + 2;
  localparam int CELLS   = LINES - 1;
  localparam int NW      = $clog2(LINES + 1);
  localparam int OW      = $clog2(MAX_OCC + 1);
  localparam int OIW     = (MAX_OCC > 1) ? $clog2(MAX_OCC) : 1;
  localparam int SIW     = $clog2(LINES);
  localparam int IN_BITS = (COORD_BITS < CW) ? COORD_BITS : CW;
  localparam int SH      = CW - IN_BITS;

  function automatic logic signed [CW-1:0] sx(input logic [CW-1:0] f);
    logic signed [CW-1:0] t;
    t = f << SH;
    return t >>> SH;
  endfunction

  // job registers
  box_t          win_r;
  logic [OW-1:0] cnt_r;
  logic          ovf_r;
  box_t          in_box;
  box_t          occ_mem [MAX_OCC];
  box_t          rd_occ_r;

  // pass control
  logic [OW-1:0] i_r;
  logic [1:0]    ph_r;
  logic          any_r;
  box_t          k;
  logic          k_empty;

  // grid
  sort_cmd_t             xs_cmd, ys_cmd;
  logic signed [CW-1:0]  xv0, yv0;
  logic [LINES-1:0][CW-1:0] xl, yl;
  logic [NW-1:0]         xn, yn, nx, ny;

  // coverage and heights
  logic [CELLS-1:0] cov_r   [CELLS];
  logic [CELLS-1:0] cov_nxt [CELLS];
  logic [CW-1:0]    hgt_r   [CELLS];
  logic [CW-1:0]    hgt_nxt [CELLS];
  logic [CELLS-1:0] colm;
  logic [CELLS-1:0] rowm;

  // sweep
  logic [NW-1:0]        row_r, col_r, sp_r;
  bar_t                 top_r, stk_rd_r;
  bar_t                 stk_mem [LINES];
  logic signed [CW-1:0] left_r;
  logic                 popped_r;
  box_t                 cand_r, best_r;
  logic [AW-1:0]        area_r, best_area_r;
  logic [CW-1:0]        rh, h, wdt;
  logic signed [CW-1:0] bottom;
  logic                 col_last, col_pop, push, adv;
  logic [AW-1:0]        prod, win_prod;

  out_word_t out_r;
  logic      out_valid_r;

  assign in_box.x0 = sx(in_word.x_min);
  assign in_box.y0 = sx(in_word.y_min);
  assign in_box.x1 = sx(in_word.x_max);
  assign in_box.y1 = sx(in_word.y_max);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.take) begin
      if (in_word.kind == KIND_WINDOW) begin
        win_r <= in_box;
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else if (cnt_r < OW'(MAX_OCC)) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        ovf_r <= 1'b1;
      end
    end else if (cmd.finish) begin
      win_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_word.kind == KIND_OCC && cnt_r < OW'(MAX_OCC))
      occ_mem[cnt_r[OIW-1:0]] <= in_box;
    rd_occ_r <= occ_mem[i_r[OIW-1:0]];
  end

  // clip to window
  always_comb begin
    k.x0 = (rd_occ_r.x0 > win_r.x0) ? rd_occ_r.x0 : win_r.x0;
    k.y0 = (rd_occ_r.y0 > win_r.y0) ? rd_occ_r.y0 : win_r.y0;
    k.x1 = (rd_occ_r.x1 < win_r.x1) ? rd_occ_r.x1 : win_r.x1;
    k.y1 = (rd_occ_r.y1 < win_r.y1) ? rd_occ_r.y1 : win_r.y1;
    k_empty = (k.x1 <= k.x0) || (k.y1 <= k.y0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r   <= '0;
      ph_r  <= '0;
      any_r <= 1'b0;
    end else if (cmd.init || cmd.check) begin
      i_r  <= '0;
      ph_r <= '0;
      if (cmd.init) any_r <= 1'b0;
    end else if (cmd.grid) begin
      unique case (ph_r)
        2'd0: ph_r <= 2'd1;
        2'd1: ph_r <= 2'd2;
        default: begin
          ph_r <= 2'd0;
          i_r  <= i_r + 1'b1;
          if (!k_empty) any_r <= 1'b1;
        end
      endcase
    end else if (cmd.mark) begin
      if (ph_r == 2'd0) begin
        ph_r <= 2'd1;
      end else begin
        ph_r <= 2'd0;
        i_r  <= i_r + 1'b1;
      end
    end
  end

  // grid line sorters
  assign xv0 = cmd.init ? win_r.x0 : ((ph_r == 2'd1) ? k.x0 : k.x1);
  assign yv0 = cmd.init ? win_r.y0 : ((ph_r == 2'd1) ? k.y0 : k.y1);

  assign adv = cmd.col && !col_pop;

  always_comb begin
    xs_cmd.init = cmd.init;
    xs_cmd.ins  = cmd.grid && ph_r != 2'd0 && !k_empty;
    xs_cmd.rot  = adv;
    xs_cmd.shf  = 1'b0;
    ys_cmd.init = cmd.init;
    ys_cmd.ins  = xs_cmd.ins;
    ys_cmd.rot  = 1'b0;
    ys_cmd.shf  = adv && col_last;
  end

  lfr_sort #(.LINES(LINES)) u_xs (
    .clk(clk), .rst_n(rst_n), .cmd(xs_cmd), .v0(xv0), .v1(win_r.x1), .line_o(xl), .n_o(xn)
  );

  lfr_sort #(.LINES(LINES)) u_ys (
    .clk(clk), .rst_n(rst_n), .cmd(ys_cmd), .v0(yv0), .v1(win_r.y1), .line_o(yl), .n_o(yn)
  );

  assign nx = xn - 1'b1;
  assign ny = yn - 1'b1;

  // coverage map and column heights
  assign rh     = CW'($signed(yl[1]) - $signed(yl[0]));
  assign bottom = $signed(yl[1]);

  for (genvar c = 0; c < CELLS; c++) begin : g_col
    localparam int NX = (c + 1) % CELLS;

    assign colm[c] = (NW'(c) < nx) && ($signed(xl[c]) >= k.x0) && ($signed(xl[c]) < k.x1);
    assign rowm[c] = (NW'(c) < ny) && ($signed(yl[c]) >= k.y0) && ($signed(yl[c]) < k.y1);

    always_comb begin
      cov_nxt[c] = cov_r[c];
      if (cmd.init) cov_nxt[c] = '0;
      else if (cmd.mark && ph_r == 2'd1 && !k_empty)
        cov_nxt[c] = cov_r[c] | (rowm[c] ? colm : '0);
      else if (adv && col_last) cov_nxt[c] = cov_r[NX];
    end

    always_comb begin
      hgt_nxt[c] = hgt_r[c];
      if (cmd.check) hgt_nxt[c] = '0;
      else if (cmd.row) hgt_nxt[c] = cov_r[0][c] ? '0 : hgt_r[c] + rh;
      else if (adv && !col_last)
        hgt_nxt[c] = (NW'(c) == nx - 1'b1 || c == CELLS - 1) ? hgt_r[0] : hgt_r[NX];
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < CELLS; r++) begin
      cov_r[r] <= cov_nxt[r];
      hgt_r[r] <= hgt_nxt[r];
    end
  end

  // histogram stack sweep
  assign col_last = (col_r == nx);
  assign h        = col_last ? '0 : hgt_r[0];
  assign col_pop  = (sp_r != '0) && (top_r.height >= h);
  assign push     = (h != '0) && (sp_r < NW'(LINES));
  assign wdt      = CW'($signed(xl[0]) - top_r.left);
  assign prod     = AW'(wdt) * AW'(top_r.height);
  assign win_prod = AW'($unsigned(CW'(win_r.x1 - win_r.x0))) *
                    AW'($unsigned(CW'(win_r.y1 - win_r.y0)));

  always_ff @(posedge clk) begin
    if (adv && push && sp_r != '0) stk_mem[SIW'(sp_r - 1'b1)] <= top_r;
    stk_rd_r <= stk_mem[SIW'(sp_r - NW'(2))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      sp_r     <= '0;
      popped_r <= 1'b0;
    end else if (cmd.check) begin
      row_r <= '0;
    end else if (cmd.row) begin
      col_r    <= '0;
      sp_r     <= '0;
      popped_r <= 1'b0;
    end else if (cmd.col) begin
      if (col_pop) begin
        sp_r     <= sp_r - 1'b1;
        popped_r <= 1'b1;
      end else begin
        if (push) sp_r <= sp_r + 1'b1;
        popped_r <= 1'b0;
        if (col_last) row_r <= row_r + 1'b1;
        else col_r <= col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col) begin
      if (col_pop) begin
        cand_r.x0 <= top_r.left;
        cand_r.y0 <= CW'(bottom - $signed(top_r.height));
        cand_r.x1 <= $signed(xl[0]);
        cand_r.y1 <= bottom;
        area_r    <= prod;
        left_r    <= top_r.left;
      end else if (push) begin
        top_r.left   <= popped_r ? left_r : $signed(xl[0]);
        top_r.height <= h;
      end
    end else if (cmd.pop) begin
      top_r <= stk_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= '0;
      best_area_r <= '0;
    end else if (cmd.init) begin
      best_r      <= '0;
      best_area_r <= '0;
    end else if (cmd.win) begin
      best_r      <= win_r;
      best_area_r <= win_prod;
    end else if (cmd.pop && area_r > best_area_r) begin
      best_r      <= cand_r;
      best_area_r <= area_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.free_x_min <= best_r.x0;
      out_r.free_y_min <= best_r.y0;
      out_r.free_x_max <= best_r.x1;
      out_r.free_y_max <= best_r.y1;
      out_r.free_area  <= best_area_r;
      out_r.dropped    <= ovf_r;
    end
  end

  assign out_word  = out_r;
  assign out_valid = out_valid_r;

  always_comb begin
    sts.win_empty = (win_r.x1 <= win_r.x0) || (win_r.y1 <= win_r.y0);
    sts.grid_done = (i_r == cnt_r);
    sts.any_clip  = any_r;
    sts.mark_done = (i_r == cnt_r);
    sts.rows_done = (row_r == ny);
    sts.col_pop   = col_pop;
    sts.col_last  = col_last;
    sts.out_free  = !out_valid_r || !out_stall;
  end

endmodule

// ===== design/lfr_ctrl.sv =====
// Controller state machine sequencing load, grid build, marking and sweep.
module lfr_ctrl import lfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid && in_last) state_nxt = ST_START;
      ST_START:  state_nxt = sts.win_empty ? ST_FINISH : ST_GRID;
      ST_GRID:   if (sts.grid_done) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = sts.any_clip ? ST_MARK : ST_WIN;
      ST_WIN:    state_nxt = ST_FINISH;
      ST_MARK:   if (sts.mark_done) state_nxt = ST_ROW;
      ST_ROW:    state_nxt = sts.rows_done ? ST_FINISH : ST_COL;
      ST_COL: begin
        if (sts.col_pop) state_nxt = ST_POP;
        else if (sts.col_last) state_nxt = ST_ROW;
      end
      ST_POP:    state_nxt = ST_COL;
      ST_FINISH: if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:   cmd.take = in_valid;
      ST_START:  cmd.init = 1'b1;
      ST_GRID:   cmd.grid = !sts.grid_done;
      ST_CHECK:  cmd.check = sts.any_clip;
      ST_WIN:    cmd.win = 1'b1;
      ST_MARK:   cmd.mark = !sts.mark_done;
      ST_ROW:    cmd.row = !sts.rows_done;
      ST_COL:    cmd.col = 1'b1;
      ST_POP:    cmd.pop = 1'b1;
      ST_FINISH: cmd.finish = sts.out_free;
      default:   cmd = '0;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule
